/* src/wlnvc_pkg.sv */
package wlnvc_pkg;

  localparam int ADDR_W_DEFAULT = 16;
  localparam int WORD_BYTES = 4;
  localparam int JOB_DEPTH = 4;

  localparam logic [15:0] BASE_ADDRESS_RESET = 16'd0;
  localparam logic [7:0] EXTRA_SLOTS_RESET = 8'd0;
  localparam logic [7:0] START_MARKER_RESET = 8'd165;
  localparam logic [7:0] STOP_MARKER_RESET = 8'd90;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_EXTRA_SLOTS = 2'd1;
  localparam logic [1:0] REG_START_MARKER = 2'd2;
  localparam logic [1:0] REG_STOP_MARKER = 2'd3;

  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_RETURN = 3'd1;
  localparam logic [2:0] CMD_INCREMENT = 3'd2;
  localparam logic [2:0] CMD_SET = 3'd3;
  localparam logic [2:0] CMD_ADD = 3'd4;
  localparam logic [2:0] CMD_TICK = 3'd5;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_COMMIT = 2'd3;

  localparam logic [2:0] JOB_NONE = 3'd0;
  localparam logic [2:0] JOB_READ = 3'd1;
  localparam logic [2:0] JOB_COMMIT = 3'd2;
  localparam logic [2:0] JOB_SLOT = 3'd3;
  localparam logic [2:0] JOB_SLOT_COMMIT = 3'd4;
  localparam logic [2:0] JOB_INIT = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [31:0] operand_value;
    logic [7:0] read_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mem_op;
    logic [15:0] mem_address;
    logic [7:0] mem_data;
    logic [31:0] counter_value;
    logic [8:0] slot_number;
    logic last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] base_address;
    logic [7:0] extra_slots;
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] count;
    logic [8:0] slot;
  } job_t;

  function automatic logic [2:0] job_last_step(input logic [2:0] kind);
    logic [2:0] last;
    unique case (kind)
      JOB_SLOT: last = 3'd4;
      JOB_SLOT_COMMIT: last = 3'd5;
      JOB_INIT: last = 3'd6;
      default: last = 3'd0;
    endcase
    return last;
  endfunction

endpackage

/* src/wlnvc_front.sv */
module wlnvc_front
  import wlnvc_pkg::*;
#(
  parameter int ADDRESS_WIDTH = ADDR_W_DEFAULT
) (
  input logic clk,
  input logic rst,
  input cfg_regs_t cfg,
  input logic base_rewrite,
  input logic [15:0] base_data,
  input logic take,
  input in_item_t item,
  output job_t job,
  output logic [ADDRESS_WIDTH-1:0] job_addr
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_SCAN = 2'd2;
  localparam logic [1:0] PH_LOAD = 2'd3;

  localparam logic [ADDRESS_WIDTH-1:0] STEP = ADDRESS_WIDTH'(WORD_BYTES);

  logic [31:0] count_reg, count_reg_next;
  logic [8:0] slot_index, slot_index_next;
  logic [ADDRESS_WIDTH-1:0] slot_address, slot_address_next;
  logic commit_pending, commit_pending_next;
  logic [1:0] phase, phase_next;
  logic [1:0] byte_counter, byte_counter_next;
  logic [31:0] held_init_value, held_init_value_next;

  logic [ADDRESS_WIDTH-1:0] base_a;
  logic [ADDRESS_WIDTH-1:0] first_slot;
  logic [ADDRESS_WIDTH-1:0] scan_addr;
  logic [8:0] scan_index;
  logic [31:0] held_merged;
  logic found;

  assign base_a = ADDRESS_WIDTH'(cfg.base_address);
  assign first_slot = base_a + ADDRESS_WIDTH'(1);
  assign found = item.read_byte == cfg.stop_marker;
  assign scan_addr = found ? slot_address : slot_address + STEP;
  assign scan_index = found ? slot_index : slot_index + 9'd1;
  assign held_merged = held_init_value | (32'(item.read_byte) << {byte_counter, 3'b000});

  always_comb begin
    count_reg_next = count_reg;
    slot_index_next = slot_index;
    slot_address_next = slot_address;
    commit_pending_next = commit_pending;
    phase_next = phase;
    byte_counter_next = byte_counter;
    held_init_value_next = held_init_value;
    job.kind = JOB_NONE;
    job_addr = '0;
    if (item.command == CMD_RETURN) begin
      unique case (phase)
        PH_START: begin
          if (item.read_byte != cfg.start_marker) begin
            count_reg_next = held_init_value;
            phase_next = PH_IDLE;
            job.kind = JOB_INIT;
            job_addr = slot_address;
          end else begin
            phase_next = PH_SCAN;
            job.kind = JOB_READ;
            job_addr = slot_address + STEP;
          end
        end
        PH_SCAN: begin
          slot_address_next = scan_addr;
          slot_index_next = scan_index;
          job.kind = JOB_READ;
          if (!found && scan_index <= {1'b0, cfg.extra_slots}) begin
            job_addr = scan_addr + STEP;
          end else begin
            phase_next = PH_LOAD;
            byte_counter_next = 2'd0;
            held_init_value_next = '0;
            job_addr = scan_addr;
          end
        end
        PH_LOAD: begin
          held_init_value_next = held_merged;
          if (byte_counter == 2'd3) begin
            count_reg_next = held_merged;
            phase_next = PH_IDLE;
            byte_counter_next = 2'd0;
          end else begin
            byte_counter_next = byte_counter + 2'd1;
            job.kind = JOB_READ;
            job_addr = slot_address + ADDRESS_WIDTH'({1'b0, byte_counter} + 3'd1);
          end
        end
        default: begin
          job.kind = JOB_NONE;
        end
      endcase
    end else if (phase == PH_IDLE) begin
      unique case (item.command)
        CMD_INIT: begin
          held_init_value_next = item.operand_value;
          slot_index_next = '0;
          slot_address_next = first_slot;
          phase_next = PH_START;
          job.kind = JOB_READ;
          job_addr = base_a;
        end
        CMD_INCREMENT: begin
          count_reg_next = count_reg + 32'd1;
          commit_pending_next = 1'b1;
          job.kind = JOB_SLOT;
          job_addr = slot_address;
        end
        CMD_SET, CMD_ADD: begin
          count_reg_next = (item.command == CMD_SET) ? item.operand_value :
                           count_reg + item.operand_value;
          job.kind = JOB_SLOT_COMMIT;
          job_addr = slot_address;
        end
        CMD_TICK: begin
          if (commit_pending) begin
            if (slot_index < {1'b0, cfg.extra_slots}) begin
              slot_address_next = slot_address + STEP;
              slot_index_next = slot_index + 9'd1;
            end else begin
              slot_address_next = first_slot;
              slot_index_next = '0;
            end
            commit_pending_next = 1'b0;
            job.kind = JOB_COMMIT;
          end
        end
        default: begin
          job.kind = JOB_NONE;
        end
      endcase
    end
    job.count = count_reg_next;
    job.slot = slot_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
      slot_index <= '0;
      slot_address <= ADDRESS_WIDTH'(BASE_ADDRESS_RESET) + ADDRESS_WIDTH'(1);
      commit_pending <= 1'b0;
      phase <= PH_IDLE;
      byte_counter <= '0;
      held_init_value <= '0;
    end else if (base_rewrite) begin
      slot_address <= ADDRESS_WIDTH'(base_data) + ADDRESS_WIDTH'(1);
      slot_index <= '0;
    end else if (take) begin
      count_reg <= count_reg_next;
      slot_index <= slot_index_next;
      slot_address <= slot_address_next;
      commit_pending <= commit_pending_next;
      phase <= phase_next;
      byte_counter <= byte_counter_next;
      held_init_value <= held_init_value_next;
    end
  end

endmodule

/* src/wlnvc_fifo.sv */
module wlnvc_fifo
  import wlnvc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input logic clk,
  input logic rst,
  input logic wr_en,
  input logic [WIDTH-1:0] wr_data,
  input logic rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(JOB_DEPTH);

  logic [WIDTH-1:0] mem [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] level;

  assign full = level == (PTR_W + 1)'(JOB_DEPTH);
  assign empty = level == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10: level <= level + (PTR_W + 1)'(1);
        2'b01: level <= level - (PTR_W + 1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

/* src/wlnvc_back.sv */
module wlnvc_back
  import wlnvc_pkg::*;
#(
  parameter int ADDRESS_WIDTH = ADDR_W_DEFAULT
) (
  input logic clk,
  input logic rst,
  input cfg_regs_t cfg,
  input logic job_valid,
  input job_t job,
  input logic [ADDRESS_WIDTH-1:0] job_addr,
  output logic job_done,
  input logic pop,
  output logic empty,
  output out_item_t result
);

  logic [2:0] step;
  logic [2:0] last_step;
  logic [2:0] slot_step;
  logic is_init;
  logic adv;
  logic out_valid;
  out_item_t res_next;
  out_item_t result_q;

  assign last_step = job_last_step(job.kind);
  assign adv = job_valid && (!out_valid || pop);
  assign job_done = adv && (step == last_step);
  assign is_init = job.kind == JOB_INIT;
  assign slot_step = is_init ? step - 3'd1 : step;
  assign empty = !out_valid;
  assign result = result_q;

  always_comb begin
    res_next = '0;
    res_next.counter_value = job.count;
    res_next.slot_number = job.slot;
    res_next.last_of_run = step == last_step;
    unique case (job.kind)
      JOB_READ: begin
        res_next.mem_op = OP_READ;
        res_next.mem_address = 16'(job_addr);
      end
      JOB_COMMIT: begin
        res_next.mem_op = OP_COMMIT;
      end
      JOB_SLOT, JOB_SLOT_COMMIT, JOB_INIT: begin
        if (is_init && step == 3'd0) begin
          res_next.mem_op = OP_WRITE;
          res_next.mem_address = 16'(ADDRESS_WIDTH'(cfg.base_address));
          res_next.mem_data = cfg.start_marker;
        end else if (slot_step < 3'd4) begin
          res_next.mem_op = OP_WRITE;
          res_next.mem_address = 16'(job_addr + ADDRESS_WIDTH'(slot_step));
          res_next.mem_data = job.count[{slot_step[1:0], 3'b000} +: 8];
        end else if (slot_step == 3'd4) begin
          res_next.mem_op = OP_WRITE;
          res_next.mem_address = 16'(job_addr + ADDRESS_WIDTH'(WORD_BYTES));
          res_next.mem_data = cfg.stop_marker;
        end else begin
          res_next.mem_op = OP_COMMIT;
        end
      end
      default: begin
        res_next.mem_op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        step <= job_done ? 3'd0 : step + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_q <= res_next;
    end
  end

endmodule

/* src/wear_leveled_nv_counter.sv */
// With the block empty, the first result of a request passes through the job queue and then
// the result register of the back end before it is shown and can be popped.
// Results leave at one per cycle while they are popped; a request causes one to seven results,
// so the sustained request rate is set by the single result register of the back end.
// Requests are classified combinationally as they are taken, and a four-entry job queue lets the front run ahead.
// Reset is synchronous and active high: it restores the register defaults and the counter state.
module wear_leveled_nv_counter
  import wlnvc_pkg::*;
#(
  parameter int ADDRESS_WIDTH = ADDR_W_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic push,
  output logic full,
  input in_item_t item,
  output logic empty,
  input logic pop,
  output out_item_t result,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [1:0] cfg_index,
  input logic [15:0] cfg_data
);

  localparam int JOB_W = $bits(job_t) + ADDRESS_WIDTH;

  cfg_regs_t cfg;
  logic cfg_we;
  logic base_rewrite;
  logic take;
  job_t job_in;
  job_t job_out;
  logic [ADDRESS_WIDTH-1:0] job_in_addr;
  logic [ADDRESS_WIDTH-1:0] job_out_addr;
  logic [JOB_W-1:0] fifo_out;
  logic fifo_empty;
  logic job_done;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;
  assign base_rewrite = cfg_we && (cfg_index == REG_BASE_ADDRESS);
  assign take = push && !full;
  assign {job_out, job_out_addr} = fifo_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= BASE_ADDRESS_RESET;
      cfg.extra_slots <= EXTRA_SLOTS_RESET;
      cfg.start_marker <= START_MARKER_RESET;
      cfg.stop_marker <= STOP_MARKER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        REG_EXTRA_SLOTS: cfg.extra_slots <= cfg_data[7:0];
        REG_START_MARKER: cfg.start_marker <= cfg_data[7:0];
        REG_STOP_MARKER: cfg.stop_marker <= cfg_data[7:0];
        default: cfg.stop_marker <= cfg.stop_marker;
      endcase
    end
  end

  wlnvc_front #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .base_rewrite(base_rewrite),
    .base_data(cfg_data),
    .take(take),
    .item(item),
    .job(job_in),
    .job_addr(job_in_addr)
  );

  wlnvc_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(take),
    .wr_data({job_in, job_in_addr}),
    .rd_en(job_done),
    .rd_data(fifo_out),
    .full(full),
    .empty(fifo_empty)
  );

  wlnvc_back #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .job_valid(!fifo_empty),
    .job(job_out),
    .job_addr(job_out_addr),
    .job_done(job_done),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

  a_first_result: assert property (@(posedge clk) disable iff (rst)
    take && empty && fifo_empty |-> ##2 !empty)
    else $error("first result of a request into an idle block did not appear in time");

  a_single_ops_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.mem_op == OP_NONE || result.mem_op == OP_READ) |->
      result.last_of_run && result.mem_data == 8'h00)
    else $error("read or empty result is not the closing result of its request");

  a_commit_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && result.mem_op == OP_COMMIT |->
      result.last_of_run && result.mem_address == 16'h0000 && result.mem_data == 8'h00)
    else $error("commit result carries an address or data, or is not the last of its request");

endmodule
